[sv/magic_keyed_message_deframer_unit_macros.svh]
// Assertion macros for the deframer.
`ifndef MAGIC_KEYED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define MAGIC_KEYED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MKD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("mkd assertion failed");
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkd assertion failed");
`else
`define MKD_ASSERT(label, clk, rst_n, prop)
`define MKD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/mkd_pkg.sv]
package mkd_pkg;

  localparam int HDR_BYTES = 4;
  localparam int Q_DEPTH   = 2;
  localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW      = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    REG_MAGIC_A  = 3'd0,
    REG_LENGTH_A = 3'd1,
    REG_MAGIC_B  = 3'd2,
    REG_LENGTH_B = 3'd3,
    REG_MAGIC_C  = 3'd4,
    REG_LENGTH_C = 3'd5,
    REG_MAGIC_V  = 3'd6,
    REG_ENABLE   = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] ENTRY_A   = 2'd0;
  localparam logic [1:0] ENTRY_B   = 2'd1;
  localparam logic [1:0] ENTRY_C   = 2'd2;
  localparam logic [1:0] ENTRY_VAR = 2'd3;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
    logic       empty_message;
    logic [1:0] matched_entry;
  } mkd_res_t;

endpackage

[sv/magic_keyed_message_deframer_unit.sv]
// A result passes through the queue and the output register on its way to the out_ ports.
// 1 byte per cycle unless full; header compares and the payload count run in the front stage.
// A 2-deep queue and an output register let the front keep going while pop is low.
// Reset: synchronous, active low; clears registers, parser state and the queue.
`include "magic_keyed_message_deframer_unit_macros.svh"

module magic_keyed_message_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_stream_byte,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_payload_byte,
  output logic        out_first_of_message,
  output logic        out_last_of_message,
  output logic        out_empty_message,
  output logic [1:0]  out_matched_entry
);
  import mkd_pkg::*;

  logic     accept;
  logic     front_valid;
  mkd_res_t front_res;
  mkd_res_t q_data;
  logic     q_full, q_empty, q_pop;
  mkd_res_t out_res;
  logic     empty_msg_ok;

  assign full   = q_full;
  assign accept = push && !q_full;

  mkd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .res_valid   (front_valid),
    .res         (front_res)
  );

  mkd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_res),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  mkd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .res     (out_res)
  );

  assign out_payload_byte     = out_res.payload_byte;
  assign out_first_of_message = out_res.first_of_message;
  assign out_last_of_message  = out_res.last_of_message;
  assign out_empty_message    = out_res.empty_message;
  assign out_matched_entry    = out_res.matched_entry;

  // an empty-message transaction carries both marks and a zero byte
  assign empty_msg_ok = !front_res.empty_message ||
                        (front_res.first_of_message && front_res.last_of_message &&
                         front_res.payload_byte == 8'd0);

  `MKD_ASSERT(a_no_overflow, clk, rst_n, !(front_valid && q_full))
  `MKD_ASSERT(a_empty_msg_marks, clk, rst_n, !front_valid || empty_msg_ok)
  `MKD_ASSERT_NEXT(a_back_refills, clk, rst_n, !q_empty && empty, !empty)

endmodule

[sv/mkd_front.sv]
module mkd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  output logic              res_valid,
  output mkd_pkg::mkd_res_t res
);
  import mkd_pkg::*;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'b001,
    PH_LENGTH  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  localparam logic [1:0] HDR_LAST = 2'(HDR_BYTES - 1);

  logic [31:0] magic_a_r, magic_b_r, magic_c_r, magic_v_r;
  logic [31:0] len_a_r, len_b_r, len_c_r;
  logic [3:0]  enable_r;

  phase_t      phase_r, phase_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [1:0]  entry_r, entry_nxt;
  logic        start_r, start_nxt;

  logic [31:0] shift;
  logic        last;
  logic        do_begin;
  logic [31:0] begin_len;
  logic [1:0]  begin_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_a_r <= '0;
      magic_b_r <= '0;
      magic_c_r <= '0;
      magic_v_r <= '0;
      len_a_r   <= '0;
      len_b_r   <= '0;
      len_c_r   <= '0;
      enable_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAGIC_A:  magic_a_r <= cfg_data;
        REG_LENGTH_A: len_a_r   <= cfg_data;
        REG_MAGIC_B:  magic_b_r <= cfg_data;
        REG_LENGTH_B: len_b_r   <= cfg_data;
        REG_MAGIC_C:  magic_c_r <= cfg_data;
        REG_LENGTH_C: len_c_r   <= cfg_data;
        REG_MAGIC_V:  magic_v_r <= cfg_data;
        REG_ENABLE:   enable_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign shift = {hdr_r[23:0], stream_byte};
  assign last  = (rem_r <= 32'd1);

  always_comb begin
    phase_nxt   = phase_r;
    hdr_nxt     = hdr_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    entry_nxt   = entry_r;
    start_nxt   = start_r;
    res_valid   = 1'b0;
    res         = '0;
    do_begin    = 1'b0;
    begin_len   = shift;
    begin_entry = entry_r;

    if (accept) begin
      unique case (phase_r)
        PH_PAYLOAD: begin
          res_valid            = 1'b1;
          res.payload_byte     = stream_byte;
          res.first_of_message = start_r;
          res.last_of_message  = last;
          res.matched_entry    = entry_r;
          start_nxt            = 1'b0;
          rem_nxt              = last ? '0 : rem_r - 32'd1;
          if (last) begin
            phase_nxt = PH_MAGIC;
            start_nxt = 1'b1;
          end
        end
        default: begin
          if (cnt_r != HDR_LAST) begin
            hdr_nxt = shift;
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            hdr_nxt = '0;
            if (phase_r == PH_LENGTH) begin
              do_begin = 1'b1;
            end else if (enable_r[0] && shift == magic_a_r) begin
              do_begin    = 1'b1;
              begin_len   = len_a_r;
              begin_entry = ENTRY_A;
            end else if (enable_r[1] && shift == magic_b_r) begin
              do_begin    = 1'b1;
              begin_len   = len_b_r;
              begin_entry = ENTRY_B;
            end else if (enable_r[2] && shift == magic_c_r) begin
              do_begin    = 1'b1;
              begin_len   = len_c_r;
              begin_entry = ENTRY_C;
            end else if (enable_r[3] && shift == magic_v_r) begin
              entry_nxt = ENTRY_VAR;
              phase_nxt = PH_LENGTH;
            end else begin
              phase_nxt = PH_MAGIC;
            end
          end
        end
      endcase

      if (do_begin) begin
        entry_nxt = begin_entry;
        start_nxt = 1'b1;
        if (begin_len == '0) begin
          // zero-length message: one marker result
          phase_nxt            = PH_MAGIC;
          res_valid            = 1'b1;
          res.first_of_message = 1'b1;
          res.last_of_message  = 1'b1;
          res.empty_message    = 1'b1;
          res.matched_entry    = begin_entry;
        end else begin
          rem_nxt   = begin_len;
          phase_nxt = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      hdr_r   <= '0;
      cnt_r   <= '0;
      rem_r   <= '0;
      entry_r <= '0;
      start_r <= 1'b1;
    end else begin
      phase_r <= phase_nxt;
      hdr_r   <= hdr_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      entry_r <= entry_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

[sv/mkd_queue.sv]
module mkd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  mkd_pkg::mkd_res_t wr_data,
  input  logic              rd_en,
  output mkd_pkg::mkd_res_t rd_data,
  output logic              q_full,
  output logic              q_empty
);
  import mkd_pkg::*;

  localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
  localparam logic [Q_CW-1:0] CNT_FULL = Q_CW'(Q_DEPTH);

  mkd_res_t        mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == CNT_FULL);
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/mkd_back.sv]
module mkd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  mkd_pkg::mkd_res_t q_data,
  output logic              q_pop,
  input  logic              pop,
  output logic              empty,
  output mkd_pkg::mkd_res_t res
);
  import mkd_pkg::*;

  logic     valid_r, valid_nxt;
  mkd_res_t res_r;

  // refill the output register whenever it is free or being drained
  assign q_pop     = !q_empty && (!valid_r || pop);
  assign valid_nxt = q_pop || (valid_r && !pop);
  assign empty     = !valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

[sim/magic_keyed_message_deframer_unit_tb.sv]
`timescale 1ns / 100ps

module magic_keyed_message_deframer_unit_tb;
  import mkd_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PAYLOAD_CAP   = 1000;

  typedef enum logic [1:0] {PH_MAGIC, PH_LENGTH, PH_PAYLOAD} frame_phase_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        cfg_we         = 1'b0;
  cfg_reg_t    cfg_index      = REG_MAGIC_A;
  logic [31:0] cfg_data       = '0;
  logic        push           = 1'b0;
  logic [7:0]  in_stream_byte = '0;
  logic        pop            = 1'b0;
  logic        full;
  logic        empty;
  logic [7:0]  out_payload_byte;
  logic        out_first_of_message;
  logic        out_last_of_message;
  logic        out_empty_message;
  logic [1:0]  out_matched_entry;

  // deframer state mirror
  logic [31:0]  magic_tbl [3]  = '{default: '0};
  logic [31:0]  length_tbl [3] = '{default: '0};
  logic [31:0]  var_magic_r    = '0;
  logic [3:0]   enable_r       = '0;
  frame_phase_t phase_m        = PH_MAGIC;
  logic [31:0]  hdr_word       = '0;
  int unsigned  hdr_cnt        = 0;
  logic [31:0]  bytes_left     = '0;
  logic [1:0]   cur_entry      = ENTRY_A;
  logic         msg_start      = 1'b1;

  mkd_res_t     expected_msgs[$];
  int unsigned  mismatch_count = 0;
  int unsigned  quiet_cycles   = 0;
  int unsigned  bytes_sent     = 0;
  int unsigned  stall_left     = 0;
  int unsigned  idle_pct       = 20;
  bit           idle_on        = 1'b1;

  magic_keyed_message_deframer_unit uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .push                 (push),
    .full                 (full),
    .in_stream_byte       (in_stream_byte),
    .empty                (empty),
    .pop                  (pop),
    .out_payload_byte     (out_payload_byte),
    .out_first_of_message (out_first_of_message),
    .out_last_of_message  (out_last_of_message),
    .out_empty_message    (out_empty_message),
    .out_matched_entry    (out_matched_entry)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // header done: zero length gives a single empty-message transaction
  function automatic void open_message(logic [31:0] len);
    mkd_res_t r;
    hdr_word  = '0;
    hdr_cnt   = 0;
    msg_start = 1'b1;
    if (len == 0) begin
      phase_m            = PH_MAGIC;
      r.payload_byte     = 8'h00;
      r.first_of_message = 1'b1;
      r.last_of_message  = 1'b1;
      r.empty_message    = 1'b1;
      r.matched_entry    = cur_entry;
      expected_msgs.push_back(r);
    end else begin
      bytes_left = len;
      phase_m    = PH_PAYLOAD;
    end
  endfunction

  function automatic void predict_deframe(logic [7:0] b);
    mkd_res_t r;
    bit       hit;
    hit = 1'b0;
    if (phase_m == PH_PAYLOAD) begin
      r.payload_byte     = b;
      r.first_of_message = msg_start;
      r.last_of_message  = (bytes_left <= 1);
      r.empty_message    = 1'b0;
      r.matched_entry    = cur_entry;
      expected_msgs.push_back(r);
      msg_start = 1'b0;
      if (r.last_of_message) begin
        bytes_left = '0;
        phase_m    = PH_MAGIC;
        msg_start  = 1'b1;
      end else begin
        bytes_left = bytes_left - 1;
      end
    end else begin
      hdr_word = {hdr_word[23:0], b};
      if (hdr_cnt < HDR_BYTES - 1) begin
        hdr_cnt++;
      end else begin
        hdr_cnt = 0;
        if (phase_m == PH_LENGTH) begin
          open_message(hdr_word);
        end else begin
          // fixed entries in priority order a, b, c
          for (int i = 0; i < 3; i++) begin
            if (!hit && enable_r[i] && hdr_word == magic_tbl[i]) begin
              hit       = 1'b1;
              cur_entry = 2'(i);
              open_message(length_tbl[i]);
            end
          end
          if (!hit) begin
            if (enable_r[3] && hdr_word == var_magic_r) begin
              cur_entry = ENTRY_VAR;
              phase_m   = PH_LENGTH;
            end
            hdr_word = '0;
          end
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // result side: random pop stalls, compare, watchdog counting
  always @(posedge clk) begin
    mkd_res_t want;
    if (!rst_n) begin
      pop          <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if ((push && !full) || (pop && !empty))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (pop && !empty) begin
        if (expected_msgs.size() == 0) begin
          report_mismatch("unexpected transaction", out_payload_byte, 0);
        end else begin
          want = expected_msgs.pop_front();
          if (out_payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", out_payload_byte, want.payload_byte);
          if (out_first_of_message !== want.first_of_message)
            report_mismatch("first_of_message", out_first_of_message, want.first_of_message);
          if (out_last_of_message !== want.last_of_message)
            report_mismatch("last_of_message", out_last_of_message, want.last_of_message);
          if (out_empty_message !== want.empty_message)
            report_mismatch("empty_message", out_empty_message, want.empty_message);
          if (out_matched_entry !== want.matched_entry)
            report_mismatch("matched_entry", out_matched_entry, want.matched_entry);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("magic_keyed_message_deframer_unit_tb: FAIL");
    $finish;
  end

  // push stays high between back-to-back bytes; only a gap or wait_idle lowers it
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push           <= 1'b1;
    in_stream_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_deframe(b);
    bytes_sent++;
  endtask

  task automatic send_word(logic [31:0] w);
    for (int i = 3; i >= 0; i--)
      send_byte(w[8*i +: 8]);
  endtask

  // magic, then the length word if the variable entry took it, then the payload
  task automatic send_frame(logic [31:0] magic, logic [31:0] len_word, int unsigned cap);
    int unsigned n;
    n = 0;
    send_word(magic);
    if (phase_m == PH_LENGTH)
      send_word(len_word);
    while (phase_m == PH_PAYLOAD && n < cap) begin
      send_byte(8'($urandom_range(0, 255)));
      n++;
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAGIC_A:  magic_tbl[0]  = v;
      REG_LENGTH_A: length_tbl[0] = v;
      REG_MAGIC_B:  magic_tbl[1]  = v;
      REG_LENGTH_B: length_tbl[1] = v;
      REG_MAGIC_C:  magic_tbl[2]  = v;
      REG_LENGTH_C: length_tbl[2] = v;
      REG_MAGIC_V:  var_magic_r   = v;
      REG_ENABLE:   enable_r      = v[3:0];
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_length();
    return ($urandom_range(0, 7) == 0) ? 32'd0 : 32'($urandom_range(1, 16));
  endfunction

  // magics sometimes collide so priority gets exercised at random too
  function automatic logic [31:0] pick_magic();
    return ($urandom_range(0, 5) == 0) ? magic_tbl[0] : $urandom;
  endfunction

  task automatic test_all_disabled();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    wait_idle();
  endtask

  task automatic test_each_entry();
    write_cfg(REG_MAGIC_A, 32'hFFFF_FFFF);
    write_cfg(REG_LENGTH_A, 32'd1);
    write_cfg(REG_MAGIC_B, 32'h0000_0000);
    write_cfg(REG_LENGTH_B, 32'd0);
    write_cfg(REG_MAGIC_C, 32'h1234_5678);
    write_cfg(REG_LENGTH_C, 32'd3);
    write_cfg(REG_MAGIC_V, 32'hA5A5_A5A5);
    write_cfg(REG_ENABLE, 32'hF);
    send_frame(32'hFFFF_FFFF, 32'd0, PAYLOAD_CAP);
    send_frame(32'h0000_0000, 32'd0, PAYLOAD_CAP);
    send_frame(32'h1234_5678, 32'd0, PAYLOAD_CAP);
    send_frame(32'hA5A5_A5A5, 32'd0, PAYLOAD_CAP);
    send_frame(32'hA5A5_A5A5, 32'd2, PAYLOAD_CAP);
    send_frame(32'hDEAD_BEEF, 32'd0, PAYLOAD_CAP);
    send_frame(32'hFFFF_FFFF, 32'd0, PAYLOAD_CAP);
    wait_idle();
  endtask

  task automatic test_entry_priority();
    logic [3:0] masks [5];
    masks = '{4'hF, 4'hE, 4'hC, 4'h8, 4'h0};
    write_cfg(REG_MAGIC_A, 32'h5A5A_5A5A);
    write_cfg(REG_MAGIC_B, 32'h5A5A_5A5A);
    write_cfg(REG_MAGIC_C, 32'h5A5A_5A5A);
    write_cfg(REG_MAGIC_V, 32'h5A5A_5A5A);
    write_cfg(REG_LENGTH_A, 32'd1);
    write_cfg(REG_LENGTH_B, 32'd2);
    write_cfg(REG_LENGTH_C, 32'd3);
    foreach (masks[i]) begin
      write_cfg(REG_ENABLE, {28'd0, masks[i]});
      send_frame(32'h5A5A_5A5A, 32'd4, PAYLOAD_CAP);
      wait_idle();
    end
  endtask

  task automatic test_random_traffic(int unsigned n_phases, int unsigned bytes_per_phase);
    int unsigned start;
    int unsigned sel;
    logic [31:0] magic;
    repeat (n_phases) begin
      wait_idle();
      write_cfg(REG_MAGIC_A, $urandom);
      write_cfg(REG_LENGTH_A, pick_length());
      write_cfg(REG_MAGIC_B, pick_magic());
      write_cfg(REG_LENGTH_B, pick_length());
      write_cfg(REG_MAGIC_C, pick_magic());
      write_cfg(REG_LENGTH_C, pick_length());
      write_cfg(REG_MAGIC_V, pick_magic());
      write_cfg(REG_ENABLE, $urandom_range(1, 15));
      if (idle_on)
        idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 20;
      start = bytes_sent;
      while (bytes_sent - start < bytes_per_phase) begin
        sel = $urandom_range(0, 9);
        // mostly frames for a configured entry; the rest unknown magics
        if (sel < 2)
          magic = $urandom;
        else if (sel < 5)
          magic = var_magic_r;
        else
          magic = magic_tbl[sel % 3];
        send_frame(magic, pick_length() + $urandom_range(0, 4), PAYLOAD_CAP);
        if ($urandom_range(0, 49) == 0)
          wait_idle();
      end
    end
  endtask

  // ends the run: the block stays in this payload for good
  task automatic test_huge_length();
    wait_idle();
    write_cfg(REG_MAGIC_A, 32'h8000_0001);
    write_cfg(REG_LENGTH_A, 32'hFFFF_FFFF);
    write_cfg(REG_ENABLE, 32'h1);
    send_frame(32'h8000_0001, 32'd0, 40);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_all_disabled();
    test_each_entry();
    test_entry_priority();
    test_random_traffic(7, 250);
    wait_idle();
    idle_on  = 1'b0;
    idle_pct = 0;
    test_random_traffic(1, 250);
    test_huge_length();
    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_msgs.size() == 0) begin
      $display("magic_keyed_message_deframer_unit_tb: PASS");
    end else begin
      $display("magic_keyed_message_deframer_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
